### rtl/aes_pkg.sv
// Package for the AES block cipher core: request codes, state machine type,
// S-box tables and GF(2^8) helpers. No dependencies.
package aes_pkg;

	localparam int KeyWords = 60;
	localparam int KeyAw = 6;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_ENC = 2'd1,
		REQ_DEC = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_ROUND,
		ST_LAST,
		ST_DONE
	} state_t;

	function automatic logic [7:0] xt(input logic [7:0] x);
		xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		fwd_sbox = t[x];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[x];
	endfunction

	// byte k sits at bits [127-8k -: 8]; row k/4, column k%4
	function automatic logic [127:0] shift_fwd(input logic [127:0] s);
		logic [127:0] o;
		o = '0;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				o[127 - 8 * (r * 4 + c) -: 8] = s[127 - 8 * (r * 4 + ((c + r) % 4)) -: 8];
		shift_fwd = o;
	endfunction

	function automatic logic [127:0] shift_inv(input logic [127:0] s);
		logic [127:0] o;
		o = '0;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				o[127 - 8 * (r * 4 + c) -: 8] = s[127 - 8 * (r * 4 + ((c + 3 * r) % 4)) -: 8];
		shift_inv = o;
	endfunction

	function automatic logic [127:0] mix_fwd(input logic [127:0] s);
		logic [127:0] o;
		logic [7:0] a [4];
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) a[r] = s[127 - 8 * (r * 4 + c) -: 8];
			for (int r = 0; r < 4; r++)
				o[127 - 8 * (r * 4 + c) -: 8] = xt(a[r]) ^ xt(a[(r + 1) % 4]) ^ a[(r + 1) % 4]
					^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
		end
		mix_fwd = o;
	endfunction

	function automatic logic [127:0] mix_inv(input logic [127:0] s);
		logic [127:0] o;
		logic [7:0] a [4];
		logic [7:0] x2, x4, x8;
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r] = s[127 - 8 * (r * 4 + c) -: 8];
				x2 = xt(a[r]);
				x4 = xt(x2);
				x8 = xt(x4);
				m9[r] = x8 ^ a[r];
				mb[r] = x8 ^ x2 ^ a[r];
				md[r] = x8 ^ x4 ^ a[r];
				me[r] = x8 ^ x4 ^ x2;
			end
			for (int r = 0; r < 4; r++)
				o[127 - 8 * (r * 4 + c) -: 8] = me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4]
					^ m9[(r + 3) % 4];
		end
		mix_inv = o;
	endfunction

endpackage

### rtl/aes_block_encrypt_decrypt.sv
// AES-128/192/256 cipher core on a preloaded round-key schedule.
// Depends on aes_pkg (S-boxes, row shift, column mix).
//
//  channel  | handshake           | payload
//  in       | in_valid / in_stall | req_type, block_high, block_low, key_index, key_word
//  out      | out_valid/out_stall | out_high, out_low, status
//  cfg      | cfg_we              | cfg_wdata (round_count)
//
// Steps: a load item writes its word and leaves the input open. An encrypt item runs
// FETCH (first key addition), ROUND for each round but the last, LAST, then DONE with
// its result; a decrypt item runs FETCH, ROUND for every round, LAST (key row 0), DONE.
// One registered key row read per round. A bad round count shows the block in the
// cycle after accept. Reset sets round_count to 10. The input stalls while an item
// is in work or its result waits; the next is taken in the cycle after the result leaves.
module aes_block_encrypt_decrypt
	import aes_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   req_type,
	input  logic [63:0]  block_high,
	input  logic [63:0]  block_low,
	input  logic [5:0]   key_index,
	input  logic [31:0]  key_word,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [63:0]  out_high,
	output logic [63:0]  out_low,
	output logic         status,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_wdata
);

	// store organized as 15 rows of four words; one row read per cycle
	localparam int Rows = KeyWords / 4;

	logic [127:0] key_mem [Rows];
	logic [127:0] rkey_q;
	logic [3:0]   rd_row;
	logic         rd_en;

	state_t       state_q, state_d;
	logic [3:0]   nr_q;
	logic [127:0] st_q;
	logic [3:0]   rnd_q;
	logic         dec_q;
	logic         status_q;
	logic         accept, nr_ok, is_cipher;

	logic [127:0] sb_out, fw_core, iv_core, round_out;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign nr_ok = (nr_q == 4'd10) || (nr_q == 4'd12) || (nr_q == 4'd14);
	assign is_cipher = (req_type == REQ_ENC) || (req_type == REQ_DEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) nr_q <= 4'd10;
		else if (cfg_we) nr_q <= cfg_wdata;
	end

	// key store: one 32-bit lane per word in each row, written one word at a time
	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_LOAD && key_index < 6'(KeyWords))
			key_mem[key_index[5:2]][127 - 32 * key_index[1:0] -: 32] <= key_word;
		if (rd_en) rkey_q <= key_mem[rd_row];
	end

	// round unit: forward = SubBytes/ShiftRows/MixColumns, inverse = InvMix/InvShift/InvSub
	always_comb begin
		for (int k = 0; k < 16; k++) begin
			sb_out[127 - 8 * k -: 8] = dec_q ? inv_sbox(iv_core[127 - 8 * k -: 8])
				: fwd_sbox(st_q[127 - 8 * k -: 8]);
		end
	end

	// row-major state vs column-major key row: rkey word c holds column c
	function automatic logic [127:0] key_to_state(input logic [127:0] w);
		logic [127:0] o;
		o = '0;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				o[127 - 8 * (r * 4 + c) -: 8] = w[127 - 32 * c - 8 * r -: 8];
		key_to_state = o;
	endfunction

	logic [127:0] kst, dec_in;
	assign kst = key_to_state(rkey_q);
	// decrypt: add key, then (unless first) inverse mix, then inverse shift
	assign dec_in = st_q ^ kst;
	assign iv_core = shift_inv((state_q == ST_ROUND && rnd_q != nr_q) ? mix_inv(dec_in) : dec_in);
	assign fw_core = shift_fwd(sb_out);

	always_comb begin
		if (dec_q) round_out = sb_out;
		else if (state_q == ST_LAST) round_out = fw_core ^ kst;
		else round_out = mix_fwd(fw_core) ^ kst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		rd_en = 1'b0;
		rd_row = rnd_q;
		unique case (state_q)
			ST_IDLE: begin
				rd_en = 1'b1;
				rd_row = (req_type == REQ_DEC) ? nr_q : 4'd0;
				if (accept && is_cipher) state_d = nr_ok ? ST_FETCH : ST_DONE;
			end
			ST_FETCH: begin
				// initial key addition (encrypt) happens here
				rd_en = 1'b1;
				rd_row = dec_q ? rnd_q : 4'd1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				rd_en = 1'b1;
				rd_row = dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
				if (dec_q ? (rnd_q == 4'd1) : (rnd_q + 4'd1 == nr_q)) state_d = ST_LAST;
			end
			ST_LAST: state_d = ST_DONE;
			ST_DONE: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			dec_q <= 1'b0;
			status_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) begin
					dec_q <= (req_type == REQ_DEC);
					status_q <= !nr_ok;
					rnd_q <= (req_type == REQ_DEC) ? nr_q : 4'd1;
				end
				ST_FETCH, ST_ROUND: if (state_q == ST_ROUND)
					rnd_q <= dec_q ? rnd_q - 4'd1 : rnd_q + 4'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		priority case (1'b1)
			(state_q == ST_IDLE && accept): st_q <= {block_high, block_low};
			(state_q == ST_FETCH): if (!dec_q) st_q <= st_q ^ kst;
			(state_q == ST_ROUND): st_q <= round_out;
			(state_q == ST_LAST): st_q <= dec_q ? st_q ^ kst : round_out;
			default: ;
		endcase
	end

	assign out_valid = (state_q == ST_DONE);
	assign out_high = st_q[127:64];
	assign out_low = st_q[63:0];
	assign status = status_q;

endmodule

### rtl/aes_chk.sv
// Port-level checker for aes_block_encrypt_decrypt, bound to the top level.
// Depends on nothing but the top level's ports.
module aes_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] out_high,
	input logic        status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_high) && $stable(status))
		else $error("result dropped under stall");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result waits");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid) else $error("result repeated");

endmodule

bind aes_block_encrypt_decrypt aes_chk u_chk (.*);

### dv/aes_block_encrypt_decrypt_tb.sv
// Self-checking testbench for aes_block_encrypt_decrypt: loads a round-key schedule,
// runs encrypt and decrypt items under several round counts and checks each block.
// Depends on aes_pkg and the block RTL.
`timescale 1ns / 1ps

class aes_scoreboard;
	typedef struct {
		bit [63:0] hi;
		bit [63:0] lo;
		bit        st;
	} block_res_t;

	block_res_t  expected_q[$];
	bit [7:0]    sbox_fwd[256];
	bit [7:0]    sbox_inv[256];
	bit [31:0]   key_store[60];
	bit [3:0]    rounds;
	int          mismatches;

	function new();
		bit [7:0] inv, b;
		rounds = 10;
		mismatches = 0;
		for (int x = 0; x < 256; x++) begin
			inv = 0;
			for (int y = 1; y < 256; y++)
				if (gmul(8'(x), 8'(y)) == 1) inv = 8'(y);
			b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			sbox_fwd[x] = b;
			sbox_inv[b] = 8'(x);
		end
	endfunction

	function bit [7:0] gmul(bit [7:0] a, bit [7:0] b);
		bit [7:0] acc;
		acc = 0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
		end
		return acc;
	endfunction

	function void add_round_key(ref bit [7:0] s[16], input int rnd);
		bit [31:0] w;
		for (int c = 0; c < 4; c++) begin
			w = key_store[rnd * 4 + c];
			for (int r = 0; r < 4; r++) s[r * 4 + c] ^= w[31 - 8 * r -: 8];
		end
	endfunction

	function void sub_shift(ref bit [7:0] s[16], input bit dec);
		bit [7:0] t[16];
		t = s;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				s[r * 4 + c] = dec ? sbox_inv[t[r * 4 + ((c + 3 * r) % 4)]]
					: sbox_fwd[t[r * 4 + ((c + r) % 4)]];
	endfunction

	function void mix(ref bit [7:0] s[16], input bit dec);
		bit [7:0] t[16];
		bit [7:0] m[4];
		bit [7:0] v;
		if (dec) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else m = '{8'h02, 8'h03, 8'h01, 8'h01};
		t = s;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				v = 0;
				for (int k = 0; k < 4; k++) v ^= gmul(m[(k + 4 - i) % 4], t[k * 4 + j]);
				s[i * 4 + j] = v;
			end
	endfunction

	function block_res_t cipher(bit dec, bit [63:0] hi, bit [63:0] lo);
		block_res_t res;
		bit [7:0] s[16];
		int nr;
		nr = rounds;
		if (!(nr == 10 || nr == 12 || nr == 14)) begin
			res = '{hi, lo, 1'b1};
			return res;
		end
		for (int k = 0; k < 8; k++) begin
			s[k] = hi[63 - 8 * k -: 8];
			s[k + 8] = lo[63 - 8 * k -: 8];
		end
		if (!dec) begin
			add_round_key(s, 0);
			for (int rnd = 1; rnd <= nr; rnd++) begin
				sub_shift(s, 0);
				if (rnd < nr) mix(s, 0);
				add_round_key(s, rnd);
			end
		end else begin
			for (int rnd = nr; rnd >= 1; rnd--) begin
				add_round_key(s, rnd);
				if (rnd < nr) mix(s, 1);
				sub_shift(s, 1);
			end
			add_round_key(s, 0);
		end
		for (int k = 0; k < 8; k++) begin
			res.hi[63 - 8 * k -: 8] = s[k];
			res.lo[63 - 8 * k -: 8] = s[k + 8];
		end
		res.st = 0;
		return res;
	endfunction

	function void note_input(aes_pkg::req_t req, bit [63:0] hi, bit [63:0] lo,
		bit [5:0] idx, bit [31:0] word);
		case (req)
			aes_pkg::REQ_LOAD: if (idx < 60) key_store[idx] = word;
			aes_pkg::REQ_ENC: expected_q.push_back(cipher(0, hi, lo));
			aes_pkg::REQ_DEC: expected_q.push_back(cipher(1, hi, lo));
			default: ;
		endcase
	endfunction

	function void check_result(bit [63:0] hi, bit [63:0] lo, bit st);
		block_res_t exp_res;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %h %h status %b", hi, lo, st);
			return;
		end
		exp_res = expected_q.pop_front();
		if (exp_res.hi !== hi || exp_res.lo !== lo || exp_res.st !== st) begin
			mismatches++;
			if (mismatches <= 10)
				$display("block mismatch: expected %h %h status %b, got %h %h status %b",
					exp_res.hi, exp_res.lo, exp_res.st, hi, lo, st);
		end
	endfunction
endclass

module aes_block_encrypt_decrypt_tb;
	import aes_pkg::*;

	localparam int CycleLimit = 600000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_NONE;
	logic [63:0] block_high = 0;
	logic [63:0] block_low = 0;
	logic [5:0]  key_index = 0;
	logic [31:0] key_word = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [63:0] out_high;
	logic [63:0] out_low;
	logic        status;
	logic        cfg_we = 0;
	logic [3:0]  cfg_wdata = 0;

	aes_scoreboard sb = new();
	bit  no_gaps = 0;
	int  cycles = 0;
	int  blocks_seen = 0;

	aes_block_encrypt_decrypt dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .block_high(block_high), .block_low(block_low),
		.key_index(key_index), .key_word(key_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_high(out_high), .out_low(out_low), .status(status),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("aes_block_encrypt_decrypt test failed");
			$finish;
		end
	end

	task automatic send_item(req_t req, bit [63:0] hi, bit [63:0] lo, bit [5:0] idx,
		bit [31:0] word);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		req_type = req;
		block_high = hi;
		block_low = lo;
		key_index = idx;
		key_word = word;
		in_valid = 1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		sb.note_input(req, hi, lo, idx, word);
		@(negedge clk);
	endtask

	task automatic send_random();
		int pick;
		bit [63:0] hi, lo;
		pick = $urandom_range(0, 99);
		hi = {$urandom, $urandom};
		lo = {$urandom, $urandom};
		if (pick < 12)
			send_item(REQ_LOAD, hi, lo, 6'($urandom_range(0, 63)), $urandom);
		else if (pick < 16)
			send_item(REQ_NONE, hi, lo, 6'($urandom_range(0, 63)), $urandom);
		else if (pick < 58)
			send_item(REQ_ENC, hi, lo, 6'($urandom_range(0, 63)), $urandom);
		else
			send_item(REQ_DEC, hi, lo, 6'($urandom_range(0, 63)), $urandom);
	endtask

	// write round_count only once the block has drained
	task automatic set_rounds(bit [3:0] value);
		in_valid = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		@(negedge clk);
		repeat (25) @(negedge clk);
		cfg_wdata = value;
		cfg_we = 1;
		@(negedge clk);
		cfg_we = 0;
		sb.rounds = value;
	endtask

	// result side: random stalls, one long hold-off to back up the input
	initial begin
		int hold;
		bit held;
		held = 0;
		forever begin
			@(negedge clk);
			if (!held && blocks_seen >= 200) begin
				held = 1;
				out_stall = 1;
				repeat (300) @(negedge clk);
			end
			hold = no_gaps ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				out_stall = 1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 0;
			forever begin
				@(posedge clk);
				if (out_valid) break;
			end
			sb.check_result(out_high, out_low, status);
			blocks_seen++;
		end
	end

	initial begin
		bit [3:0] settings[6];
		settings = '{4'd14, 4'd12, 4'd0, 4'd15, 4'd10, 4'd5};
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// fill the whole schedule before any block is processed
		for (int i = 0; i < 60; i++)
			send_item(REQ_LOAD, 0, 0, 6'(i), i == 0 ? 32'h0 : i == 59 ? 32'hffffffff : $urandom);
		send_item(REQ_ENC, 64'h0, 64'h0, 0, 0);
		send_item(REQ_ENC, '1, '1, 0, 0);
		send_item(REQ_DEC, 64'h0, 64'h0, 0, 0);
		send_item(REQ_DEC, '1, '1, 63, 32'hffffffff);
		send_item(REQ_NONE, '1, '1, 63, 32'hffffffff);
		send_item(REQ_LOAD, 0, 0, 63, 32'hdeadbeef);
		send_item(REQ_LOAD, 0, 0, 60, 32'h12345678);
		send_item(REQ_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210, 0, 0);

		for (int p = 0; p <= 6; p++) begin
			if (p > 0) set_rounds(settings[p - 1]);
			for (int n = 0; n < 185; n++) begin
				no_gaps = (n >= 150);
				send_random();
			end
			no_gaps = 0;
		end

		in_valid = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("aes_block_encrypt_decrypt test passed");
		else
			$display("aes_block_encrypt_decrypt test failed");
		$finish;
	end
endmodule
